// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// SJF scheduler assertion macros
// Concurrent assertion helpers for the top level, the only RTL file that carries checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds whenever ante holds, outside reset.
`define SJF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that expr never holds, outside reset.
`define SJF_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ===== rtl/sjf_pkg.sv =====
// ----------------------------------------------------------------------------
// SJF scheduler package
// Sizes, record layout, controller states and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sjf_pkg;

    localparam int MAX_PROCS  = 16;
    localparam int TIME_WIDTH = 16;
    localparam int IDX_W      = $clog2(MAX_PROCS);
    localparam int CNT_W      = $clog2(MAX_PROCS + 1);
    localparam int FIELD_W    = 16;
    localparam int TIME_W     = 21;
    localparam int IN_W       = 48;
    localparam int OUT_W      = 112;

    // Arrival and burst keep only their low TIME_WIDTH bits.
    localparam logic [FIELD_W-1:0] TIME_MASK =
        FIELD_W'((65'(1) << TIME_WIDTH) - 65'(1));

    typedef struct packed {
        logic [FIELD_W-1:0] bur;
        logic [FIELD_W-1:0] arr;
        logic [FIELD_W-1:0] id;
    } rec_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_LOAD,
        WR_HOLD_J,
        WR_HOLD_I,
        WR_HOLD_PICK
    } wr_sel_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SO_RDI,
        ST_SO_LDI,
        ST_SO_CHK,
        ST_SO_CMP,
        ST_SO_WRI,
        ST_SC_RDI,
        ST_SC_LDI,
        ST_SC_CHK,
        ST_SC_CMP,
        ST_SC_SWP,
        ST_SC_EMIT
    } ctl_state_t;

    typedef struct packed {
        wr_sel_t wr_sel;
        logic    rd_en;
        logic    rd_j;
        logic    hold_ld;
        logic    sched_init;
        logic    best_ld;
        logic    i_clr;
        logic    i_inc;
        logic    j_init;
        logic    j_inc;
        logic    start_ld;
        logic    emit;
        logic    cnt_clr;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic j_end;
        logic i_last;
        logic arr_gt;
        logic late;
        logic bur_lt;
        logic pick_ne_i;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/sjf_nonpreemptive_scheduler.sv =====
// Non-preemptive shortest-job-first scheduler.
// The slave channel takes one process record per request; tlast marks the
// last record of a set and starts the schedule. Records beyond 16 are dropped,
// but a dropped record that carries tlast still starts the schedule.
// The master channel returns one result per held record, in scheduled order,
// with tlast on the final one. While loading, s_tready stays high, so no request waits.
// Both the arrival sort and the selection walk the record table through its
// single registered read port.
// While a set is sorted or scheduled, s_tready stays low.
// Results leave through an output register, so the block computes the next
// result while the previous one waits; a stalled receiver only holds the
// block once a second result is ready. Once the last result is in the output
// register the block takes records for the next set.
// Reset empties the set and drops any pending result; table contents are not
// cleared and are never read before they are written.
// ----------------------------------------------------------------------------
// SJF scheduler top level
// Joins the controller and the datapath and checks their cooperation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sjf_nonpreemptive_scheduler
    import sjf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // s_tdata, lowest bit up: proc_id[15:0], arrival[31:16], burst[47:32].
    input  logic [IN_W-1:0]  s_tdata,
    // s_tlast: is_last, the final record of the set.
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    // m_tdata, lowest bit up: proc_id_res[15:0], arrival_res[31:16],
    // burst_res[47:32], completion[68:48], turnaround[89:69],
    // waiting[110:90], zero pad[111].
    output logic [OUT_W-1:0] m_tdata,
    // m_tlast: last_result, the final result of the schedule.
    output logic             m_tlast
);

    cmd_t cmd;
    sts_t sts;

    // The controller sequences every table access and every counter step.
    sjf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the table, the schedule clock and the result register.
    sjf_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A result may only be loaded when the output register can take it.
    `SJF_ASSERT_IMPLY(a_emit_free, aclk, aresetn, cmd.emit, sts.out_free, "result overwritten")

    // Table writes from the input happen only on an accepted request.
    `SJF_ASSERT_IMPLY(a_load_acc, aclk, aresetn, cmd.wr_sel == WR_LOAD, s_tvalid && s_tready, "load write without request")

    // Turnaround is burst plus waiting.
    `SJF_ASSERT_IMPLY(a_turn, aclk, aresetn, m_tvalid, m_tdata[89:69] == (21'(m_tdata[47:32]) + m_tdata[110:90]), "turnaround mismatch")

    // Completion is arrival plus turnaround.
    `SJF_ASSERT_IMPLY(a_comp, aclk, aresetn, m_tvalid, m_tdata[68:48] == (21'(m_tdata[31:16]) + m_tdata[89:69]), "completion mismatch")

endmodule

// ===== rtl/sjf_dpath.sv =====
// ----------------------------------------------------------------------------
// SJF scheduler datapath
// Record table, loop counters, compare logic, schedule clock and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sjf_dpath
    import sjf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tlast
);

    rec_t mem [MAX_PROCS];

    rec_t              rd_data_reg;
    rec_t              hold_reg;
    rec_t              best_reg;
    rec_t              out_rec_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  i_reg;
    logic [CNT_W-1:0]  j_reg;
    logic [IDX_W-1:0]  pick_reg;
    logic [TIME_W-1:0] cur_time_reg;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] wt_reg;
    logic [TIME_W-1:0] comp_reg;
    logic [TIME_W-1:0] turn_reg;
    logic [TIME_W-1:0] out_wt_reg;
    logic              last_reg;
    logic              m_tvalid_reg;

    rec_t              in_rec;
    rec_t              wr_data;
    logic [IDX_W-1:0]  wr_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [CNT_W-1:0]  i_plus1;
    logic [TIME_W-1:0] best_bur_ext;
    logic [TIME_W-1:0] best_arr_ext;

    assign in_rec.id  = s_tdata[15:0];
    assign in_rec.arr = s_tdata[31:16] & TIME_MASK;
    assign in_rec.bur = s_tdata[47:32] & TIME_MASK;

    assign i_plus1      = i_reg + CNT_W'(1);
    assign best_bur_ext = TIME_W'(best_reg.bur);
    assign best_arr_ext = TIME_W'(best_reg.arr);

    always_comb begin
        wr_en   = 1'b1;
        wr_data = hold_reg;
        unique case (cmd.wr_sel)
            WR_LOAD: begin
                wr_en   = !sts.full;
                wr_addr = cnt_reg[IDX_W-1:0];
                wr_data = in_rec;
            end
            WR_HOLD_J:    wr_addr = j_reg[IDX_W-1:0];
            WR_HOLD_I:    wr_addr = i_reg[IDX_W-1:0];
            WR_HOLD_PICK: wr_addr = pick_reg;
            default: begin
                wr_en   = 1'b0;
                wr_addr = i_reg[IDX_W-1:0];
            end
        endcase
    end

    assign rd_addr = cmd.rd_j ? j_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign sts.full      = (cnt_reg == CNT_W'(MAX_PROCS));
    assign sts.j_end     = (j_reg >= cnt_reg);
    assign sts.i_last    = (i_plus1 == cnt_reg);
    assign sts.arr_gt    = (hold_reg.arr > rd_data_reg.arr);
    assign sts.late      = (TIME_W'(rd_data_reg.arr) > cur_time_reg);
    assign sts.bur_lt    = (rd_data_reg.bur < best_reg.bur);
    assign sts.pick_ne_i = (pick_reg != i_reg[IDX_W-1:0]);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.cnt_clr) begin
                cnt_reg <= '0;
            end else if (cmd.wr_sel == WR_LOAD && !sts.full) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Counters and working values, always set before they are used.
    always_ff @(posedge aclk) begin
        if (cmd.i_clr) begin
            i_reg <= '0;
        end else if (cmd.i_inc) begin
            i_reg <= i_plus1;
        end
        if (cmd.j_init) begin
            j_reg <= i_plus1;
        end else if (cmd.j_inc) begin
            j_reg <= j_reg + CNT_W'(1);
        end
        if (cmd.hold_ld) begin
            hold_reg <= rd_data_reg;
        end
        if (cmd.sched_init) begin
            best_reg <= rd_data_reg;
            pick_reg <= i_reg[IDX_W-1:0];
            // The clock starts at the earliest arrival.
            if (i_reg == '0) begin
                cur_time_reg <= TIME_W'(rd_data_reg.arr);
            end
        end else if (cmd.best_ld) begin
            best_reg <= rd_data_reg;
            pick_reg <= j_reg[IDX_W-1:0];
        end
        if (cmd.start_ld) begin
            if (cur_time_reg > best_arr_ext) begin
                start_reg <= cur_time_reg;
                wt_reg    <= cur_time_reg - best_arr_ext;
            end else begin
                start_reg <= best_arr_ext;
                wt_reg    <= '0;
            end
        end
        if (cmd.emit) begin
            out_rec_reg  <= best_reg;
            comp_reg     <= start_reg + best_bur_ext;
            turn_reg     <= wt_reg + best_bur_ext;
            out_wt_reg   <= wt_reg;
            last_reg     <= sts.i_last;
            cur_time_reg <= start_reg + best_bur_ext;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {1'b0, out_wt_reg, turn_reg, comp_reg,
                       out_rec_reg.bur, out_rec_reg.arr, out_rec_reg.id};

endmodule

// ===== rtl/sjf_ctrl.sv =====
// ----------------------------------------------------------------------------
// SJF scheduler controller
// Sequences loading, the arrival sort and the shortest-job selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sjf_ctrl
    import sjf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  logic s_tlast,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.wr_sel = WR_NONE;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.wr_sel = WR_LOAD;
                    if (s_tlast) begin
                        cmd.i_clr  = 1'b1;
                        state_next = ST_SO_RDI;
                    end
                end
            end
            ST_SO_RDI: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SO_LDI;
            end
            ST_SO_LDI: begin
                cmd.hold_ld = 1'b1;
                cmd.j_init  = 1'b1;
                state_next  = ST_SO_CHK;
            end
            ST_SO_CHK: begin
                if (sts.j_end) begin
                    state_next = ST_SO_WRI;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_j   = 1'b1;
                    state_next = ST_SO_CMP;
                end
            end
            ST_SO_CMP: begin
                // Exchange: the held record goes to j, the earlier one is held.
                if (sts.arr_gt) begin
                    cmd.wr_sel  = WR_HOLD_J;
                    cmd.hold_ld = 1'b1;
                end
                cmd.j_inc  = 1'b1;
                state_next = ST_SO_CHK;
            end
            ST_SO_WRI: begin
                cmd.wr_sel = WR_HOLD_I;
                if (sts.i_last) begin
                    cmd.i_clr  = 1'b1;
                    state_next = ST_SC_RDI;
                end else begin
                    cmd.i_inc  = 1'b1;
                    state_next = ST_SO_RDI;
                end
            end
            ST_SC_RDI: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SC_LDI;
            end
            ST_SC_LDI: begin
                cmd.hold_ld    = 1'b1;
                cmd.sched_init = 1'b1;
                cmd.j_init     = 1'b1;
                state_next     = ST_SC_CHK;
            end
            ST_SC_CHK: begin
                if (sts.j_end) begin
                    state_next = ST_SC_SWP;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_j   = 1'b1;
                    state_next = ST_SC_CMP;
                end
            end
            ST_SC_CMP: begin
                if (sts.late) begin
                    state_next = ST_SC_SWP;
                end else begin
                    cmd.best_ld = sts.bur_lt;
                    cmd.j_inc   = 1'b1;
                    state_next  = ST_SC_CHK;
                end
            end
            ST_SC_SWP: begin
                if (sts.pick_ne_i) begin
                    cmd.wr_sel = WR_HOLD_PICK;
                end
                cmd.start_ld = 1'b1;
                state_next   = ST_SC_EMIT;
            end
            ST_SC_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.i_last) begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_LOAD;
                    end else begin
                        cmd.i_inc  = 1'b1;
                        state_next = ST_SC_RDI;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// SJF scheduler testbench
// Loads process sets through the slave stream and checks each scheduled
// result against a local model of the arrival sort and the shortest-job-first
// selection. Both stream sides idle at random in two of three idling mixes; the third has none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import sjf_pkg::*;

    localparam int HALF_PERIOD  = 5;
    // A full set of 16 can keep the block busy with no handshake at all, and the
    // receiver may stall on top of that.
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 700;
    localparam int PHASE_ITEMS  = 160;
    localparam int REPORT_MAX   = 10;
    localparam int DIR_ROWS     = 23;

    // One row of stimulus. Where typed is set, the expected result of a
    // single-record set is written out in the row itself.
    typedef struct packed {
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] arr;
        logic [FIELD_W-1:0] bur;
        logic               last;
        logic               typed;
        logic [TIME_W-1:0]  completion;
        logic [TIME_W-1:0]  turnaround;
        logic [TIME_W-1:0]  waiting;
    } stim_row_t;

    // One scheduled process as it leaves the master stream.
    typedef struct packed {
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] arr;
        logic [FIELD_W-1:0] bur;
        logic [TIME_W-1:0]  completion;
        logic [TIME_W-1:0]  turnaround;
        logic [TIME_W-1:0]  waiting;
        logic               last;
    } sched_result_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             s_tlast  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    sjf_nonpreemptive_scheduler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Directed sets. The first two rows are single-record sets at the field
    // extremes. Then comes a set of three with a tie on burst, where the
    // earlier record must win because only a strictly smaller burst replaces
    // the pick. Then a full set of sixteen with arrival ties, idle gaps and
    // the widest waits, closed by a seventeenth record that is dropped but
    // still starts the schedule. The final row shows that the count was
    // cleared by that schedule.
    stim_row_t directed_rows [DIR_ROWS] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 21'h000000, 21'h000000, 21'h0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 21'h01FFFE, 21'h00FFFF, 21'h0},
        '{16'h0011, 16'h0008, 16'h0004, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h0012, 16'h0002, 16'h0009, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h0013, 16'h0003, 16'h0004, 1'b1, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h0100, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h0101, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h0102, 16'h0007, 16'h0003, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h0103, 16'h0007, 16'h0001, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h0104, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h0105, 16'h0003, 16'h0003, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h0106, 16'h0003, 16'h0003, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h0107, 16'h8000, 16'h0010, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h0108, 16'h0000, 16'h0000, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h0109, 16'h0010, 16'h8000, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h010A, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h010B, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h010C, 16'h0001, 16'hFFFE, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h010D, 16'hFFFE, 16'h0001, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h010E, 16'h0020, 16'h0002, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h010F, 16'h0004, 16'h0002, 1'b0, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h0110, 16'h0000, 16'h0000, 1'b1, 1'b0, 21'h0, 21'h0, 21'h0},
        '{16'h1234, 16'h0100, 16'h0020, 1'b1, 1'b1, 21'h000120, 21'h000020, 21'h0}
    };

    // Local copy of the process table and its fill level.
    logic [FIELD_W-1:0] held_id  [MAX_PROCS];
    logic [FIELD_W-1:0] held_arr [MAX_PROCS];
    logic [FIELD_W-1:0] held_bur [MAX_PROCS];
    int                 held_count = 0;

    sched_result_t expected_results [$];
    sched_result_t fresh_results    [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int random_items  = 0;
    int error_count   = 0;
    int quiet_cycles  = 0;

    sched_result_t seen_result;
    sched_result_t oldest_result;

    function automatic void swap_held(int a, int b);
        logic [FIELD_W-1:0] tmp;
        tmp = held_id[a];  held_id[a]  = held_id[b];  held_id[b]  = tmp;
        tmp = held_arr[a]; held_arr[a] = held_arr[b]; held_arr[b] = tmp;
        tmp = held_bur[a]; held_bur[a] = held_bur[b]; held_bur[b] = tmp;
    endfunction

    // Sorts the held set by arrival, then walks it in shortest-job-first
    // order and appends one result per record to fresh_results.
    function automatic void schedule_held_set();
        int unsigned   clock_now;
        int unsigned   wait_ticks;
        int unsigned   turn_ticks;
        int unsigned   best_bur;
        int            pick;
        sched_result_t res;
        for (int i = 0; i < held_count; i++) begin
            for (int j = i + 1; j < held_count; j++) begin
                if (held_arr[i] > held_arr[j]) begin
                    swap_held(i, j);
                end
            end
        end
        clock_now = held_arr[0];
        for (int i = 0; i < held_count; i++) begin
            best_bur = held_bur[i];
            pick     = i;
            // Only records that have already arrived are candidates; the
            // scan stops at the first one that arrives later.
            for (int j = i + 1; j < held_count; j++) begin
                if (held_arr[j] > clock_now) begin
                    break;
                end
                if (held_bur[j] < best_bur) begin
                    best_bur = held_bur[j];
                    pick     = j;
                end
            end
            if (pick != i) begin
                swap_held(pick, i);
            end
            wait_ticks = (clock_now > held_arr[i]) ? clock_now - held_arr[i] : 0;
            turn_ticks = held_bur[i] + wait_ticks;
            clock_now  = held_arr[i] + turn_ticks;
            res.id         = held_id[i];
            res.arr        = held_arr[i];
            res.bur        = held_bur[i];
            res.completion = TIME_W'(clock_now);
            res.turnaround = TIME_W'(turn_ticks);
            res.waiting    = TIME_W'(wait_ticks);
            res.last       = (i == held_count - 1);
            fresh_results.push_back(res);
        end
        held_count = 0;
    endfunction

    // Takes one accepted record into the local table. A record that finds
    // the table full is dropped, but its tlast still starts the schedule.
    function automatic void absorb_record(stim_row_t row);
        if (held_count < MAX_PROCS) begin
            held_id[held_count]  = row.id;
            held_arr[held_count] = row.arr & TIME_MASK;
            held_bur[held_count] = row.bur & TIME_MASK;
            held_count++;
        end
        if (row.last) begin
            schedule_held_set();
        end
    endfunction

    // Presents one request, possibly after a random gap, and waits for the
    // handshake. It returns right after the edge that accepted the request,
    // so the caller assigns s_tvalid at most once in that time step.
    task automatic send_request(stim_row_t row);
        sched_result_t typed_result;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row.bur, row.arr, row.id};
        s_tlast  <= row.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        absorb_record(row);
        if (row.typed) begin
            fresh_results.delete();
            typed_result = '{row.id, row.arr, row.bur, row.completion,
                             row.turnaround, row.waiting, 1'b1};
            expected_results.push_back(typed_result);
        end else begin
            while (fresh_results.size() != 0) begin
                expected_results.push_back(fresh_results.pop_front());
            end
        end
    endtask

    // Holds the sender off until every expected result has come back. The
    // task always waits for a clock edge, so s_tvalid is never assigned twice in a step.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    // One random set. Most sets are small; some fill the table and a few
    // overflow it. Narrow value spans give arrival ties and overlapping
    // jobs, which is where the selection logic does its real work; the full
    // span reaches every bit of every field.
    task automatic send_random_set();
        int          set_size;
        int unsigned arr_span;
        int unsigned bur_span;
        int unsigned roll;
        stim_row_t   row;
        roll = $urandom_range(99);
        if (roll < 70) begin
            set_size = $urandom_range(5, 1);
        end else if (roll < 85) begin
            set_size = $urandom_range(12, 6);
        end else if (roll < 95) begin
            set_size = MAX_PROCS;
        end else begin
            set_size = $urandom_range(MAX_PROCS + 4, MAX_PROCS + 1);
        end
        case ($urandom_range(2))
            0:       arr_span = 20;
            1:       arr_span = 1000;
            default: arr_span = 65535;
        endcase
        bur_span = $urandom_range(1) ? 20 : 65535;
        for (int k = 0; k < set_size; k++) begin
            row     = '0;
            row.id  = FIELD_W'($urandom);
            row.arr = FIELD_W'($urandom_range(arr_span));
            row.bur = FIELD_W'($urandom_range(bur_span));
            if ($urandom_range(19) == 0) begin
                row.arr = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
            if ($urandom_range(19) == 0) begin
                row.bur = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
            row.last = (k == set_size - 1);
            send_request(row);
            // Records past the table's capacity are ignored by the block.
            if (k < MAX_PROCS) begin
                random_items++;
            end
        end
    endtask

    // Receiver side: random back-pressure, the result checker and the
    // quiet-cycle counter for the watchdog. Outputs are sampled at the edge,
    // before any of this edge's updates take effect.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            seen_result.id         = m_tdata[15:0];
            seen_result.arr        = m_tdata[31:16];
            seen_result.bur        = m_tdata[47:32];
            seen_result.completion = m_tdata[68:48];
            seen_result.turnaround = m_tdata[89:69];
            seen_result.waiting    = m_tdata[110:90];
            seen_result.last       = m_tlast;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX) begin
                    $display("%0t: result with no request pending: id=%h", $realtime,
                             seen_result.id);
                end
            end else begin
                oldest_result = expected_results.pop_front();
                if (seen_result !== oldest_result) begin
                    error_count++;
                    if (error_count <= REPORT_MAX) begin
                        $display("%0t: mismatch exp id=%h arr=%h bur=%h cmp=%0d tat=%0d wt=%0d l=%b",
                                 $realtime, oldest_result.id, oldest_result.arr,
                                 oldest_result.bur, oldest_result.completion,
                                 oldest_result.turnaround, oldest_result.waiting,
                                 oldest_result.last);
                        $display("%0t:          got id=%h arr=%h bur=%h cmp=%0d tat=%0d wt=%0d l=%b",
                                 $realtime, seen_result.id, seen_result.arr,
                                 seen_result.bur, seen_result.completion,
                                 seen_result.turnaround, seen_result.waiting,
                                 seen_result.last);
                    end
                end
            end
        end
    end

    // Watchdog: the run ends if no request and no result moves for too long.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("FAIL sjf_nonpreemptive_scheduler");
        $finish;
    end

    // Main sequence: reset, the directed table, then three random phases
    // with different idling mixes. Each phase starts only once the previous
    // one has fully drained.
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 19;
        recv_idle_pct = 83;
        foreach (directed_rows[r]) begin
            send_request(directed_rows[r]);
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 19;
                    recv_idle_pct = 83;
                end
                1: begin
                    send_idle_pct = 83;
                    recv_idle_pct = 19;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            hold_until_drained();
            while (random_items < PHASE_ITEMS * (ph + 1)) begin
                send_random_set();
                // Now and then the sender waits for the block to empty.
                if ($urandom_range(19) == 0) begin
                    hold_until_drained();
                end
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("PASS sjf_nonpreemptive_scheduler");
        end else begin
            $display("FAIL sjf_nonpreemptive_scheduler");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sjf_pkg.sv
rtl/sjf_dpath.sv
rtl/sjf_ctrl.sv
rtl/sjf_nonpreemptive_scheduler.sv
tb/sv/testbench.sv
